// File: rtl/vgfm_pkg.sv
// shared types, codes and the direction function for the voxel greedy face mesher
`default_nettype none

package vgfm_pkg;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_MESH  = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [1:0] MASK_NONE  = 2'd0;
    localparam logic [1:0] MASK_BACK  = 2'd1;
    localparam logic [1:0] MASK_FRONT = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_FACE = 1'b1;

    localparam int unsigned MAX_RES = 16;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_OUT,
        S_MB_CUR,
        S_MB_PREV,
        S_MB_WR,
        S_SC_RD,
        S_SC_T,
        S_W_RD,
        S_W_CHK,
        S_H_RD,
        S_H_CHK,
        S_SRC_RD,
        S_SRC_CAP,
        S_CLR_WR,
        S_EMIT,
        S_FLUSH
    } t_state;

    typedef struct packed {
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
        logic [2:0] dir;
        logic [7:0] src;
        logic [4:0] w;
        logic [4:0] h;
    } t_face;

    typedef struct packed {
        logic       kind;
        logic [7:0] read_data;
        t_face      face;
        logic       last;
    } t_result;

    // direction from axis and back/front
    function automatic logic [2:0] dir_code(input logic [1:0] axis, input logic [1:0] t);
        logic front;
        front = (t == MASK_FRONT);
        case (axis)
            AXIS_X:  dir_code = front ? 3'd2 : 3'd3;
            AXIS_Y:  dir_code = front ? 3'd4 : 3'd5;
            AXIS_Z:  dir_code = front ? 3'd0 : 3'd1;
            default: dir_code = 3'd0;
        endcase
    endfunction

endpackage

`default_nettype wire

// File: rtl/vgfm_ram.sv
// single write port, single registered read port memory
`default_nettype none

module vgfm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/voxel_greedy_face_mesher.sv
// voxel greedy face mesher top level
`default_nettype none

// Holds a CHUNK_SIZE^3 store of block types and a CHUNK_SIZE^2 face mask, both in
// memories with one write port and one registered read port, worked by one
// sequencer that issues at most one memory access a cycle. After reset a clearing
// pass zeroes the store with the input not ready. A write goes to the store as it
// is accepted. A mesh request with row 0 first builds the mask, reading the current
// and previous plane and writing the mask for each cell, then scans the row: each
// mask cell is read and tested, a found face is widened along the row and grown
// over the following rows, its owning block is read and its mask cells cleared.
// Faces leave through one output register, each held until the next is found so
// that the final one carries tlast.
module voxel_greedy_face_mesher #(
    parameter int unsigned CHUNK_SIZE = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // pos_x, pos_y, pos_z, block_type, axis, slice_index, row_index, zero fill
    input  wire logic [31:0] i_s_tdata,
    // op
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // read_data, face_x, face_y, face_z, face_dir, source_block, face_width,
    // face_height, zero fill
    output logic      [47:0] o_m_tdata,
    // result_kind
    output logic      [0:0]  o_m_tuser,
    output logic             o_m_tlast
);

    import vgfm_pkg::*;

    localparam int unsigned CW   = $clog2(CHUNK_SIZE);
    localparam int unsigned IW   = CW + 1;
    localparam int unsigned VD   = CHUNK_SIZE * CHUNK_SIZE * CHUNK_SIZE;
    localparam int unsigned VAW  = $clog2(VD);
    localparam int unsigned MD   = CHUNK_SIZE * CHUNK_SIZE;
    localparam int unsigned MAW  = $clog2(MD);
    localparam logic [IW-1:0]  C_I   = IW'(CHUNK_SIZE);
    localparam logic [CW-1:0]  C_M1  = CW'(CHUNK_SIZE - 1);
    localparam logic [VAW:0]   V_M1  = (VAW + 1)'(VD - 1);
    localparam logic [4:0]     CNT_MAX = 5'(MAX_RES);

    function automatic logic [VAW-1:0] vox_addr(input logic [1:0] axis,
                                                input logic [CW-1:0] sp,
                                                input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [CW-1:0] x, y, z;
        case (axis)
            AXIS_X:  begin x = sp; y = a;  z = b;  end
            AXIS_Y:  begin x = a;  y = sp; z = b;  end
            default: begin x = a;  y = b;  z = sp; end
        endcase
        vox_addr = VAW'(x) + VAW'(CHUNK_SIZE) * (VAW'(y) + VAW'(CHUNK_SIZE) * VAW'(z));
    endfunction

    function automatic logic [MAW-1:0] mask_addr(input logic [CW-1:0] col,
                                                 input logic [CW-1:0] row);
        mask_addr = MAW'(col) + MAW'(row) * MAW'(CHUNK_SIZE);
    endfunction

    // input fields
    logic [3:0] in_px, in_py, in_pz, in_row;
    logic [7:0] in_bt;
    logic [1:0] in_axis;
    logic [4:0] in_slice;
    logic       in_acc;
    logic       in_pos_ok;

    assign in_px    = i_s_tdata[3:0];
    assign in_py    = i_s_tdata[7:4];
    assign in_pz    = i_s_tdata[11:8];
    assign in_bt    = i_s_tdata[19:12];
    assign in_axis  = i_s_tdata[21:20];
    assign in_slice = i_s_tdata[26:22];
    assign in_row   = i_s_tdata[30:27];
    assign in_acc   = i_s_tvalid && o_s_tready;
    assign in_pos_ok = (32'(in_px) < CHUNK_SIZE) && (32'(in_py) < CHUNK_SIZE)
                    && (32'(in_pz) < CHUNK_SIZE);

    t_state          r_state, n_state;
    logic [VAW:0]    r_clr, n_clr;
    logic [1:0]      r_axis, n_axis;
    logic [4:0]      r_slice, n_slice;
    logic [CW-1:0]   r_row, n_row;
    logic            r_cur_ok, n_cur_ok;
    logic            r_prev_ok, n_prev_ok;
    logic            r_ok, n_ok;
    logic [CW-1:0]   r_bi, n_bi, r_bj, n_bj;
    logic [7:0]      r_cur, n_cur;
    logic [IW-1:0]   r_i, n_i, r_w, n_w, r_h, n_h;
    logic [CW-1:0]   r_k, n_k, r_lx, n_lx, r_ly, n_ly;
    logic [1:0]      r_t, n_t;
    logic [7:0]      r_src, n_src;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_pend_v, n_pend_v;
    t_face           r_pend, n_pend;
    logic            r_ov, n_ov;
    t_result         r_out, n_out;

    logic            vox_we, vox_re, msk_we, msk_re;
    logic [VAW-1:0]  vox_waddr, vox_raddr;
    logic [7:0]      vox_wdata, vox_q;
    logic [MAW-1:0]  msk_waddr, msk_raddr;
    logic [1:0]      msk_wdata, msk_q;

    logic            can_push;
    logic [CW-1:0]   sp_cur, sp_prev;
    logic [IW-1:0]   i_plus_w, row_plus_h;
    logic [1:0]      mb_val;
    logic [7:0]      mb_prev;
    t_face           new_face;

    vgfm_ram #(.WIDTH(8), .DEPTH(VD), .AW(VAW)) u_vox (
        .i_clk   (i_clk),
        .i_we    (vox_we),
        .i_waddr (vox_waddr),
        .i_wdata (vox_wdata),
        .i_re    (vox_re),
        .i_raddr (vox_raddr),
        .o_rdata (vox_q)
    );

    vgfm_ram #(.WIDTH(2), .DEPTH(MD), .AW(MAW)) u_mask (
        .i_clk   (i_clk),
        .i_we    (msk_we),
        .i_waddr (msk_waddr),
        .i_wdata (msk_wdata),
        .i_re    (msk_re),
        .i_raddr (msk_raddr),
        .o_rdata (msk_q)
    );

    assign can_push   = !r_ov || i_m_tready;
    assign sp_cur     = CW'(r_slice);
    assign sp_prev    = CW'(r_slice - 5'd1);
    assign i_plus_w   = r_i + r_w;
    assign row_plus_h = IW'(r_row) + r_h;
    assign mb_prev    = r_prev_ok ? vox_q : 8'd0;

    always_comb begin
        logic [7:0] cur_v;
        cur_v = r_cur_ok ? r_cur : 8'd0;
        if (mb_prev != 8'd0 && cur_v == 8'd0) begin
            mb_val = MASK_BACK;
        end else if (mb_prev == 8'd0 && cur_v != 8'd0) begin
            mb_val = MASK_FRONT;
        end else begin
            mb_val = MASK_NONE;
        end
    end

    always_comb begin
        case (r_axis)
            AXIS_X:  begin
                new_face.x = r_slice; new_face.y = 5'(r_i); new_face.z = 5'(r_row);
            end
            AXIS_Y:  begin
                new_face.x = 5'(r_i); new_face.y = r_slice; new_face.z = 5'(r_row);
            end
            default: begin
                new_face.x = 5'(r_i); new_face.y = 5'(r_row); new_face.z = r_slice;
            end
        endcase
        new_face.dir = dir_code(r_axis, r_t);
        new_face.src = r_src;
        new_face.w   = 5'(r_w);
        new_face.h   = 5'(r_h);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_ov     <= n_ov;
            r_pend_v <= n_pend_v;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_axis    <= n_axis;
        r_slice   <= n_slice;
        r_row     <= n_row;
        r_cur_ok  <= n_cur_ok;
        r_prev_ok <= n_prev_ok;
        r_ok      <= n_ok;
        r_bi      <= n_bi;
        r_bj      <= n_bj;
        r_cur     <= n_cur;
        r_i       <= n_i;
        r_w       <= n_w;
        r_h       <= n_h;
        r_k       <= n_k;
        r_lx      <= n_lx;
        r_ly      <= n_ly;
        r_t       <= n_t;
        r_src     <= n_src;
        r_pend    <= n_pend;
        r_out     <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_axis    = r_axis;
        n_slice   = r_slice;
        n_row     = r_row;
        n_cur_ok  = r_cur_ok;
        n_prev_ok = r_prev_ok;
        n_ok      = r_ok;
        n_bi      = r_bi;
        n_bj      = r_bj;
        n_cur     = r_cur;
        n_i       = r_i;
        n_w       = r_w;
        n_h       = r_h;
        n_k       = r_k;
        n_lx      = r_lx;
        n_ly      = r_ly;
        n_t       = r_t;
        n_src     = r_src;
        n_cnt     = r_cnt;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_ov      = (r_ov && i_m_tready) ? 1'b0 : r_ov;
        n_out     = r_out;
        vox_we    = 1'b0;
        vox_waddr = vox_addr(AXIS_X, CW'(in_px), CW'(in_py), CW'(in_pz));
        vox_wdata = in_bt;
        vox_re    = 1'b0;
        vox_raddr = vox_addr(AXIS_X, CW'(in_px), CW'(in_py), CW'(in_pz));
        msk_we    = 1'b0;
        msk_waddr = mask_addr(r_bi, r_bj);
        msk_wdata = MASK_NONE;
        msk_re    = 1'b0;
        msk_raddr = mask_addr(CW'(r_i), r_row);
        o_s_tready = 1'b0;

        case (r_state)
            S_CLEAR: begin
                vox_we    = 1'b1;
                vox_waddr = r_clr[VAW-1:0];
                vox_wdata = 8'd0;
                n_clr     = r_clr + 1'b1;
                if (r_clr == V_M1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_tready = 1'b1;
                n_axis    = in_axis;
                n_slice   = in_slice;
                n_row     = CW'(in_row);
                n_cur_ok  = 32'(in_slice) < CHUNK_SIZE;
                n_prev_ok = (in_slice != 5'd0) && (32'(in_slice) <= CHUNK_SIZE);
                n_ok      = in_pos_ok;
                n_bi      = '0;
                n_bj      = '0;
                n_i       = '0;
                n_cnt     = '0;
                if (in_acc) begin
                    case (i_s_tuser)
                        OP_WRITE: begin
                            vox_we = in_pos_ok;
                        end
                        OP_READ: begin
                            // address taken while the request is still on the bus
                            vox_re  = 1'b1;
                            n_state = S_RD_OUT;
                        end
                        OP_MESH: begin
                            if (in_axis == AXIS_X || in_axis == AXIS_Y
                                || in_axis == AXIS_Z) begin
                                if (in_row == 4'd0) begin
                                    n_state = S_MB_CUR;
                                end else if (32'(in_row) < CHUNK_SIZE) begin
                                    n_state = S_SC_RD;
                                end
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_RD_OUT: begin
                if (can_push) begin
                    n_ov            = 1'b1;
                    n_out           = '0;
                    n_out.kind      = KIND_READ;
                    n_out.read_data = r_ok ? vox_q : 8'd0;
                    n_out.last      = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_MB_CUR: begin
                vox_re    = 1'b1;
                vox_raddr = vox_addr(r_axis, sp_cur, r_bi, r_bj);
                n_state   = S_MB_PREV;
            end
            S_MB_PREV: begin
                vox_re    = 1'b1;
                vox_raddr = vox_addr(r_axis, sp_prev, r_bi, r_bj);
                n_cur     = vox_q;
                n_state   = S_MB_WR;
            end
            S_MB_WR: begin
                msk_we    = 1'b1;
                msk_waddr = mask_addr(r_bi, r_bj);
                msk_wdata = mb_val;
                n_state   = S_MB_CUR;
                if (r_bi == C_M1) begin
                    n_bi = '0;
                    n_bj = r_bj + 1'b1;
                    if (r_bj == C_M1) begin
                        n_state = S_SC_RD;
                    end
                end else begin
                    n_bi = r_bi + 1'b1;
                end
            end
            S_SC_RD: begin
                if (r_i == C_I || r_cnt == CNT_MAX) begin
                    n_state = S_FLUSH;
                end else begin
                    msk_re    = 1'b1;
                    msk_raddr = mask_addr(CW'(r_i), r_row);
                    n_state   = S_SC_T;
                end
            end
            S_SC_T: begin
                if (msk_q == MASK_NONE) begin
                    n_i     = r_i + 1'b1;
                    n_state = S_SC_RD;
                end else begin
                    n_t     = msk_q;
                    n_w     = IW'(1);
                    n_state = S_W_RD;
                end
            end
            S_W_RD: begin
                n_h = IW'(1);
                n_k = '0;
                if (i_plus_w == C_I) begin
                    n_state = S_H_RD;
                end else begin
                    msk_re    = 1'b1;
                    msk_raddr = mask_addr(CW'(i_plus_w), r_row);
                    n_state   = S_W_CHK;
                end
            end
            S_W_CHK: begin
                if (msk_q == r_t) begin
                    n_w     = r_w + 1'b1;
                    n_state = S_W_RD;
                end else begin
                    n_state = S_H_RD;
                end
            end
            S_H_RD: begin
                if (row_plus_h == C_I) begin
                    n_state = S_SRC_RD;
                end else begin
                    msk_re    = 1'b1;
                    msk_raddr = mask_addr(CW'(r_i) + r_k, CW'(row_plus_h));
                    n_state   = S_H_CHK;
                end
            end
            S_H_CHK: begin
                if (msk_q != r_t) begin
                    n_state = S_SRC_RD;
                end else begin
                    n_state = S_H_RD;
                    if (IW'(r_k) + IW'(1) == r_w) begin
                        n_k = '0;
                        n_h = r_h + 1'b1;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_SRC_RD: begin
                // back faces belong to the block one step below the plane
                vox_re    = 1'b1;
                vox_raddr = vox_addr(r_axis, (r_t == MASK_BACK) ? sp_prev : sp_cur,
                                     CW'(r_i), r_row);
                n_state   = S_SRC_CAP;
            end
            S_SRC_CAP: begin
                n_src   = ((r_t == MASK_BACK) ? r_prev_ok : r_cur_ok) ? vox_q : 8'd0;
                n_lx    = '0;
                n_ly    = '0;
                n_state = S_CLR_WR;
            end
            S_CLR_WR: begin
                msk_we    = 1'b1;
                msk_waddr = mask_addr(CW'(r_i) + r_lx, r_row + r_ly);
                msk_wdata = MASK_NONE;
                if (IW'(r_lx) + IW'(1) == r_w) begin
                    n_lx = '0;
                    n_ly = r_ly + 1'b1;
                    if (IW'(r_ly) + IW'(1) == r_h) begin
                        n_state = S_EMIT;
                    end
                end else begin
                    n_lx = r_lx + 1'b1;
                end
            end
            S_EMIT: begin
                if (!r_pend_v || can_push) begin
                    if (r_pend_v) begin
                        n_ov       = 1'b1;
                        n_out      = '0;
                        n_out.kind = KIND_FACE;
                        n_out.face = r_pend;
                        n_out.last = 1'b0;
                    end
                    n_pend   = new_face;
                    n_pend_v = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    n_i      = i_plus_w;
                    n_state  = S_SC_RD;
                end
            end
            S_FLUSH: begin
                if (!r_pend_v) begin
                    n_state = S_IDLE;
                end else if (can_push) begin
                    n_ov       = 1'b1;
                    n_out      = '0;
                    n_out.kind = KIND_FACE;
                    n_out.face = r_pend;
                    n_out.last = 1'b1;
                    n_pend_v   = 1'b0;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {4'd0, r_out.face.h, r_out.face.w, r_out.face.src,
                         r_out.face.dir, r_out.face.z, r_out.face.y, r_out.face.x,
                         r_out.read_data};

`ifndef ASSERT_OFF
    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("face left pending when idle");
    a_read_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_READ) |-> o_m_tlast)
        else $error("read result without last");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_MAX)
        else $error("face count beyond limit");
    a_extent_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_H_RD) |-> (r_w != '0 && r_h != '0))
        else $error("empty extent in height probe");
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |=> !(r_state == S_RD_OUT || r_state == S_MB_CUR
                                   || r_state == S_SC_RD))
        else $error("item started during clearing pass");
`endif

endmodule

`default_nettype wire

// File: verif/testbench.sv
// self-checking testbench for the voxel greedy face mesher
`default_nettype none

module testbench;
    import vgfm_pkg::*;

    localparam int CS = 16;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] px;
        logic [3:0] py;
        logic [3:0] pz;
        logic [7:0] bt;
        logic [1:0] axis;
        logic [4:0] slice;
        logic [3:0] row;
    } t_req;

    typedef struct packed {
        logic       kind;
        logic [7:0] rd;
        logic [4:0] fx;
        logic [4:0] fy;
        logic [4:0] fz;
        logic [2:0] dir;
        logic [7:0] src;
        logic [4:0] w;
        logic [4:0] h;
        logic       last;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;
    logic [1:0]  i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [47:0] o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        o_m_tlast;

    voxel_greedy_face_mesher u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .o_m_tdata(o_m_tdata), .o_m_tuser(o_m_tuser), .o_m_tlast(o_m_tlast)
    );

    // shadow state
    logic [7:0] shadow_voxels [CS*CS*CS] = '{default: 8'd0};
    logic [1:0] shadow_mask [CS*CS] = '{default: MASK_NONE};
    bit         mask_built = 1'b0;

    t_req  pending_reqs[$];
    t_res  expected_faces[$];
    int    mismatches = 0;
    bit    quiet;
    bit    hold_sink;
    bit    hold_start;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic void queue_req(t_req q);
        pending_reqs = {pending_reqs, q};
    endfunction

    function automatic void add_expected(t_res r);
        expected_faces = {expected_faces, r};
    endfunction

    function automatic logic [7:0] voxel_at(int x, int y, int z);
        if (x < 0 || x >= CS || y < 0 || y >= CS || z < 0 || z >= CS)
            return 8'd0;
        return shadow_voxels[x + CS*(y + CS*z)];
    endfunction

    function automatic void build_face_mask(int d, int u, int v, int s);
        int c[3];
        logic [7:0] cur, prv;
        for (int j = 0; j < CS; j++) begin
            for (int i = 0; i < CS; i++) begin
                c[d] = s; c[u] = i; c[v] = j;
                cur = (s < CS) ? voxel_at(c[0], c[1], c[2]) : 8'd0;
                c[d] = s - 1;
                prv = (s > 0) ? voxel_at(c[0], c[1], c[2]) : 8'd0;
                if (prv != 0 && cur == 0)      shadow_mask[i + CS*j] = MASK_BACK;
                else if (prv == 0 && cur != 0) shadow_mask[i + CS*j] = MASK_FRONT;
                else                           shadow_mask[i + CS*j] = MASK_NONE;
            end
        end
    endfunction

    // works out the results of one accepted request and updates the shadow state
    function automatic void predict_request(t_req q);
        int d, u, v, s, j, i, w, h, cnt, c[3];
        logic [1:0] t;
        bit stop;
        t_res r;
        d = q.axis; s = q.slice; j = q.row; cnt = 0; i = 0;
        if (q.op == OP_WRITE) begin
            shadow_voxels[q.px + CS*(q.py + CS*q.pz)] = q.bt;
            return;
        end
        if (q.op == OP_READ) begin
            r = '0;
            r.kind = KIND_READ;
            r.rd = voxel_at(q.px, q.py, q.pz);
            r.last = 1'b1;
            add_expected(r);
            return;
        end
        if (q.op != OP_MESH || q.axis > AXIS_Z) return;
        u = (d == 0) ? 1 : 0;
        v = (d == 2) ? 1 : 2;
        if (j == 0) begin
            build_face_mask(d, u, v, s);
            mask_built = 1;
        end
        while (i < CS && cnt < MAX_RES) begin
            t = shadow_mask[CS*j + i];
            if (t == MASK_NONE) begin
                i++;
                continue;
            end
            for (w = 1; i + w < CS && shadow_mask[CS*j + i + w] == t; w++) ;
            stop = 0;
            for (h = 1; j + h < CS; h++) begin
                for (int k = 0; k < w; k++)
                    if (shadow_mask[CS*j + i + k + h*CS] != t) stop = 1;
                if (stop) break;
            end
            c[d] = s; c[u] = i; c[v] = j;
            r = '0;
            r.kind = KIND_FACE;
            r.fx = 5'(c[0]); r.fy = 5'(c[1]); r.fz = 5'(c[2]);
            r.dir = dir_code_tb(q.axis, t);
            if (t == MASK_BACK) c[d] = s - 1;
            r.src = voxel_at(c[0], c[1], c[2]);
            r.w = 5'(w); r.h = 5'(h);
            for (int ly = 0; ly < h; ly++)
                for (int lx = 0; lx < w; lx++)
                    shadow_mask[CS*j + i + lx + ly*CS] = MASK_NONE;
            add_expected(r);
            cnt++;
            i += w;
        end
        if (cnt > 0) expected_faces[$].last = 1'b1;
    endfunction

    function automatic logic [2:0] dir_code_tb(logic [1:0] ax, logic [1:0] t);
        case (ax)
            AXIS_X:  return (t == MASK_FRONT) ? 3'd2 : 3'd3;
            AXIS_Y:  return (t == MASK_FRONT) ? 3'd4 : 3'd5;
            default: return (t == MASK_FRONT) ? 3'd0 : 3'd1;
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d want %0d", what, got, want);
        mismatches++;
    endtask

    // acceptance seen at the rising edge, consumed at the next falling edge
    logic o_s_tready_q;

    // driver
    int src_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
            i_s_tuser  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready_q) begin
                void'(pending_reqs.pop_front());
            end
            if (src_gap > 0) src_gap--;
            else if (!quiet && $urandom_range(0, 12) == 0) src_gap = $urandom_range(1, 17);
            if (pending_reqs.size() > 0 && src_gap == 0) begin
                i_s_tvalid <= 1'b1;
                {i_s_tuser, i_s_tdata} <= {pending_reqs[0].op,
                    1'b0, pending_reqs[0].row, pending_reqs[0].slice, pending_reqs[0].axis,
                    pending_reqs[0].bt, pending_reqs[0].pz, pending_reqs[0].py,
                    pending_reqs[0].px};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        o_s_tready_q <= 1'b0;
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            o_s_tready_q <= 1'b1;
            predict_request(pending_reqs[0]);
        end
    end

    // sink readiness
    int sink_gap = 0;
    always @(negedge i_clk) begin
        if (sink_gap > 0) sink_gap--;
        else if (!quiet && $urandom_range(0, 10) == 0) sink_gap = $urandom_range(1, 17);
        i_m_tready <= (sink_gap == 0) && !hold_sink;
    end

    // long sink hold-off, counted here
    initial begin
        hold_sink = 1'b0;
        wait (hold_start);
        hold_sink = 1'b1;
        repeat (400) @(posedge i_clk);
        hold_sink = 1'b0;
    end

    // monitor
    t_res got, want;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '0;
            got.kind = o_m_tuser[0];
            {got.h, got.w, got.src, got.dir, got.fz, got.fy, got.fx, got.rd} = o_m_tdata[43:0];
            got.last = o_m_tlast;
            if (expected_faces.size() == 0) begin
                report_mismatch("unexpected result kind", got.kind, -1);
            end else begin
                want = expected_faces.pop_front();
                if (got.kind != want.kind) report_mismatch("kind", got.kind, want.kind);
                if (got.rd != want.rd)     report_mismatch("read_data", got.rd, want.rd);
                if (got.fx != want.fx)     report_mismatch("face_x", got.fx, want.fx);
                if (got.fy != want.fy)     report_mismatch("face_y", got.fy, want.fy);
                if (got.fz != want.fz)     report_mismatch("face_z", got.fz, want.fz);
                if (got.dir != want.dir)   report_mismatch("face_dir", got.dir, want.dir);
                if (got.src != want.src)   report_mismatch("source_block", got.src, want.src);
                if (got.w != want.w)       report_mismatch("face_width", got.w, want.w);
                if (got.h != want.h)       report_mismatch("face_height", got.h, want.h);
                if (got.last != want.last) report_mismatch("last", got.last, want.last);
            end
        end
    end

    function automatic t_req make_req(int op, int x, int y, int z, int bt,
                                      int ax, int sl, int rw);
        t_req q;
        q.op = 2'(op); q.px = 4'(x); q.py = 4'(y); q.pz = 4'(z); q.bt = 8'(bt);
        q.axis = 2'(ax); q.slice = 5'(sl); q.row = 4'(rw);
        return q;
    endfunction

    // a whole slice: row 0 then the other rows in order, random noise fields
    task automatic queue_slice(int ax, int sl);
        for (int r = 0; r < CS; r++)
            queue_req(make_req(OP_MESH, $urandom, $urandom, $urandom,
                               $urandom, ax, sl, r));
    endtask

    task automatic queue_blob();
        int x0, y0, z0, bt;
        x0 = $urandom_range(0, 15); y0 = $urandom_range(0, 15); z0 = $urandom_range(0, 15);
        bt = $urandom_range(1, 3) == 1 ? $urandom_range(1, 255) : $urandom_range(1, 2);
        for (int k = 0; k < $urandom_range(2, 8); k++)
            queue_req(make_req(OP_WRITE, (x0 + $urandom_range(0, 3)) % CS,
                (y0 + $urandom_range(0, 3)) % CS, (z0 + $urandom_range(0, 3)) % CS, bt,
                $urandom, $urandom, $urandom));
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_faces.size() > 0) @(posedge i_clk);
    endtask

    int total;
    initial begin
        quiet = 0; hold_start = 0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;

        // directed: extremes, every op, unused op and axis, planes at the edges
        queue_req(make_req(OP_READ, 15, 15, 15, 0, 0, 0, 0));
        queue_req(make_req(OP_WRITE, 0, 0, 0, 255, 3, 31, 15));
        queue_req(make_req(OP_WRITE, 15, 15, 15, 1, 0, 0, 0));
        queue_req(make_req(OP_WRITE, 1, 0, 0, 7, 0, 0, 0));
        queue_req(make_req(OP_READ, 0, 0, 0, 0, 0, 0, 0));
        queue_req(make_req(OP_READ, 15, 15, 15, 255, 3, 31, 15));
        queue_req(make_req(3, 15, 15, 15, 255, 3, 31, 15));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, 3, 0, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_X, 0, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_X, 1, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_X, 2, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_Y, 16, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_Y, 16, 15));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_Z, 0, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_Z, 31, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_Z, 16, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_Z, 1, 0));
        queue_req(make_req(OP_MESH, 0, 0, 0, 0, AXIS_X, 5, 7));
        wait_drained();

        // sender pause until everything is out, then a long sink hold-off
        hold_start = 1;
        for (int k = 0; k < 12; k++)
            queue_req(make_req(OP_READ, k, k, k, 0, 0, 0, 0));
        wait (hold_sink);
        wait (!hold_sink);
        wait_drained();

        total = 0;
        while (total < 400) begin
            case ($urandom_range(0, 5))
                0, 1: begin
                    queue_blob();
                    total += 5;
                end
                2: begin
                    queue_slice($urandom_range(0, 2), $urandom_range(0, 16));
                    total += CS;
                end
                3: begin
                    queue_req(make_req(OP_READ, $urandom, $urandom, $urandom,
                                       $urandom, $urandom, $urandom, $urandom));
                    total++;
                end
                4: begin
                    // partial slice, noisy rows after row 0
                    queue_req(make_req(OP_MESH, $urandom, $urandom, $urandom,
                        $urandom, $urandom_range(0, 2), $urandom_range(0, 16), 0));
                    for (int k = 0; k < 3; k++)
                        queue_req(make_req(OP_MESH, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom_range(0, 31),
                            $urandom_range(1, 15)));
                    total += 4;
                end
                default: begin
                    queue_req(make_req($urandom_range(0, 3), $urandom, $urandom,
                        $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 15)));
                    total++;
                end
            endcase
            // rows other than 0 only once a mask exists
            while (!mask_built && pending_reqs.size() > 0) @(posedge i_clk);
            if (total > 340) quiet = 1;
            while (pending_reqs.size() > 20) @(posedge i_clk);
        end
        quiet = 1;
        wait_drained();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule

`default_nettype wire
